### src/first_fit_block_allocator_macros.svh
// Assertion shorthands for the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FFBA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define FFBA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ffba_pkg.sv
package ffba_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 64;
  localparam int unsigned MAX_BLOCKS_DEF  = 64;

  localparam int unsigned POOL_W  = 13;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned BLK_W   = 7;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [POOL_W-1:0] POOL_RESET = 13'd4096;

  // register index, taken from paddr[2]
  localparam logic REG_POOL = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_OVER_POOL  = 3'd2,
    ST_OVER_FREE  = 3'd3,
    ST_NO_RUN     = 3'd4,
    ST_TABLE_FULL = 3'd5,
    ST_NOT_FOUND  = 3'd6
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    clr;
    logic    run_step;
    logic    slot_step;
    logic    take_slot;
    logic    fill_step;
    logic    cmp_step;
    logic    rel_entry;
    logic    emit;
    status_t code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic size_zero;
    logic over_pool;
    logic over_free;
    logic run_end;
    logic run_found;
    logic slot_end;
    logic slot_free;
    logic hit;
    logic last_entry;
    logic fill_last;
  } sts_t;

endpackage

### src/first_fit_block_allocator.sv
// First-fit block allocator over a pool of BLOCK_BYTES-sized blocks.
// Input channel (s_*): one request per handshake. s_tuser is the opcode
// (allocate or free); s_tdata carries the allocate size and the free offset.
// Output channel (m_*): exactly one result per request, in request order:
// status, region byte offset and region block count (zero on any error).
// Config: APB register pool_bytes at address 0, to be written by the user
// only while idle; the block itself does not enforce this.
// Allocate (N = MAX_BLOCKS, B = blocks of the region): size checks, a bitmap
// scan (one block a cycle, up to N), a table slot scan (one entry a cycle, up
// to N), then the B-block fill. Free: a registered table read then a compare
// per entry searched (up to N entries), then B blocks released in the bitmap.
// Early rejects (zero, over pool, over free) go from the size check to the result.
// The single bitmap/table sequencer sets the rate: one request at a time.
// A finished result sits in the output register; the next request is taken
// while it waits, but that request's result waits until the first one leaves.
// Reset (rst, synchronous) empties the bitmap and table valid bits, clears
// the used-byte count and sets pool_bytes to 4096; no clearing pass needed.
module first_fit_block_allocator #(
  parameter int unsigned BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ffba_pkg::S_DATA_W-1:0]  s_tdata,   // request_bytes[15:0], free_offset[27:16]
  input  logic                           s_tuser,   // opcode: 0 allocate, 1 free
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ffba_pkg::M_DATA_W-1:0]  m_tdata,   // status[2:0], region_offset[14:3],
                                                    // region_blocks[21:15]
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [ffba_pkg::POOL_W-1:0] pool_bytes;
  logic                        cfg_wr;
  ffba_pkg::cmd_t              cmd;
  ffba_pkg::sts_t              sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // pool size register; paddr[2] selects the register, low bits are byte lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes <= ffba_pkg::POOL_RESET;
    end else if (cfg_wr && (paddr[2] == ffba_pkg::REG_POOL)) begin
      pool_bytes <= pwdata[ffba_pkg::POOL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ffba_pkg::REG_POOL) ? 32'(pool_bytes) : '0;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .pool_bytes (pool_bytes),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .m_tdata    (m_tdata)
  );

endmodule

### src/ffba_datapath.sv
module ffba_datapath #(
  parameter int unsigned BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ffba_pkg::POOL_W-1:0]     pool_bytes,
  input  logic [ffba_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  ffba_pkg::cmd_t                  cmd,
  output ffba_pkg::sts_t                  sts,
  output logic [ffba_pkg::M_DATA_W-1:0]   m_tdata
);

  localparam int unsigned IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CAP = MAX_BLOCKS * BLOCK_BYTES;
  localparam int unsigned AW  = $clog2(CAP + 1);
  localparam int unsigned XW  = (AW > 17) ? AW : 17;
  localparam int unsigned OW  = (AW > ffba_pkg::OFF_W) ? AW : ffba_pkg::OFF_W;
  localparam int unsigned BW  = (CW > ffba_pkg::BLK_W) ? CW : ffba_pkg::BLK_W;
  localparam int unsigned PW  = ffba_pkg::POOL_W;
  localparam int unsigned EW  = IW + CW + PW;

  localparam logic [XW-1:0] BB_X  = XW'(BLOCK_BYTES);
  localparam logic [XW-1:0] CAP_X = XW'(CAP);

  logic                          op;
  logic [ffba_pkg::REQ_W-1:0]    req;
  logic [ffba_pkg::OFF_W-1:0]    off;

  logic [CW-1:0] idx;
  logic [CW-1:0] left;
  logic [CW-1:0] blocks;
  logic [CW-1:0] run_cnt;
  logic [AW-1:0] addr;
  logic [AW-1:0] run_bytes;
  logic [AW-1:0] run_addr;
  logic [IW-1:0] run_start;
  logic [PW-1:0] used_bytes;

  logic [MAX_BLOCKS-1:0] block_used;
  logic [MAX_BLOCKS-1:0] entry_valid;

  // allocation table: {start, blocks, bytes}
  logic [EW-1:0] entry_mem [MAX_BLOCKS];
  logic [EW-1:0] rd_q;

  logic [IW-1:0] rd_start;
  logic [CW-1:0] rd_blocks;
  logic [PW-1:0] rd_bytes;

  logic [PW-1:0] eff;
  logic [PW-1:0] avail;
  logic [XW-1:0] run_bytes_nx;
  logic [XW-1:0] prod;
  logic          cur_used;
  logic          at_end;
  logic [OW-1:0] off_w;
  logic [BW-1:0] blk_w;

  logic [ffba_pkg::STAT_W-1:0] res_status;
  logic [ffba_pkg::OFF_W-1:0]  res_off;
  logic [ffba_pkg::BLK_W-1:0]  res_blk;

  assign rd_start  = rd_q[EW-1 -: IW];
  assign rd_blocks = rd_q[CW+PW-1:PW];
  assign rd_bytes  = rd_q[PW-1:0];

  always_comb begin
    eff   = (XW'(pool_bytes) > CAP_X) ? PW'(CAP) : pool_bytes;
    avail = (used_bytes > eff) ? '0 : eff - used_bytes;
    cur_used = block_used[idx[IW-1:0]];
    // block idx lies inside the pool when idx*BLOCK_BYTES < effective pool
    at_end = (idx == CW'(MAX_BLOCKS)) || (XW'(addr) >= XW'(eff));
    run_bytes_nx = ((run_cnt == '0) ? '0 : XW'(run_bytes)) + BB_X;
    prod = XW'(rd_start) * BB_X;
    off_w = OW'(run_addr);
    blk_w = BW'(blocks);

    sts.size_zero  = (req == '0);
    sts.over_pool  = (req > ffba_pkg::REQ_W'(eff));
    sts.over_free  = (req > ffba_pkg::REQ_W'(avail));
    sts.run_end    = at_end;
    sts.run_found  = !cur_used && (run_bytes_nx >= XW'(req));
    sts.slot_end   = at_end;
    sts.slot_free  = !entry_valid[idx[IW-1:0]];
    sts.hit        = entry_valid[idx[IW-1:0]] && (prod == XW'(off));
    sts.last_entry = (idx == CW'(MAX_BLOCKS - 1));
    sts.fill_last  = (left == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= s_tuser;
      req <= s_tdata[ffba_pkg::REQ_W-1:0];
      off <= s_tdata[ffba_pkg::REQ_W +: ffba_pkg::OFF_W];
    end

    if (cmd.clr) begin
      idx  <= '0;
      addr <= '0;
    end else if (cmd.take_slot) begin
      idx <= CW'(run_start);
    end else if (cmd.rel_entry) begin
      idx <= CW'(rd_start);
    end else if (cmd.run_step || cmd.slot_step || cmd.fill_step || cmd.cmp_step) begin
      idx  <= idx + CW'(1);
      addr <= addr + AW'(BLOCK_BYTES);
    end

    if (cmd.clr) begin
      run_cnt   <= '0;
      run_bytes <= '0;
    end else if (cmd.run_step) begin
      if (cur_used) begin
        run_cnt <= '0;
      end else begin
        run_cnt   <= run_cnt + CW'(1);
        run_bytes <= AW'(run_bytes_nx);
      end
    end

    // run capture survives the clear issued on the final scan step
    if (cmd.run_step && !cur_used) begin
      if (run_cnt == '0) begin
        run_start <= idx[IW-1:0];
        run_addr  <= addr;
      end
      blocks <= run_cnt + CW'(1);
    end else if (cmd.rel_entry) begin
      run_addr <= AW'(prod);
      blocks   <= rd_blocks;
    end

    if (cmd.take_slot) begin
      left <= blocks;
    end else if (cmd.rel_entry) begin
      left <= rd_blocks;
    end else if (cmd.fill_step) begin
      left <= left - CW'(1);
    end

    if (cmd.take_slot) begin
      entry_mem[idx[IW-1:0]] <= {run_start, blocks, req[PW-1:0]};
    end
    rd_q <= entry_mem[idx[IW-1:0]];

    if (cmd.emit) begin
      res_status <= cmd.code;
      if (cmd.code == ffba_pkg::ST_OK) begin
        res_off <= off_w[ffba_pkg::OFF_W-1:0];
        res_blk <= blk_w[ffba_pkg::BLK_W-1:0];
      end else begin
        res_off <= '0;
        res_blk <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_bytes  <= '0;
      block_used  <= '0;
      entry_valid <= '0;
    end else begin
      if (cmd.take_slot) begin
        used_bytes <= used_bytes + req[PW-1:0];
        entry_valid[idx[IW-1:0]] <= 1'b1;
      end else if (cmd.rel_entry) begin
        used_bytes <= (used_bytes > rd_bytes) ? used_bytes - rd_bytes : '0;
        entry_valid[idx[IW-1:0]] <= 1'b0;
      end
      if (cmd.fill_step) begin
        block_used[idx[IW-1:0]] <= (op == ffba_pkg::OP_ALLOC);
      end
    end
  end

  assign m_tdata = {2'b00, res_blk, res_off, res_status};

endmodule

### src/ffba_ctrl.sv
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tuser,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_SLOT,
    S_FILL,
    S_FRD,
    S_FCMP,
    S_FIN
  } state_t;

  state_t            state;
  ffba_pkg::status_t code;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rst && (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.code = code;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          cmd.clr  = 1'b1;
        end
      end
      S_RUN: begin
        if (!sts.run_end) begin
          cmd.run_step = 1'b1;
          cmd.clr      = sts.run_found;
        end
      end
      S_SLOT: begin
        if (!sts.slot_end) begin
          cmd.take_slot = sts.slot_free;
          cmd.slot_step = !sts.slot_free;
        end
      end
      S_FILL: cmd.fill_step = 1'b1;
      S_FCMP: begin
        if (sts.hit) begin
          cmd.rel_entry = 1'b1;
        end else if (!sts.last_entry) begin
          cmd.cmp_step = 1'b1;
        end
      end
      S_FIN:  cmd.emit = out_free;
      default: cmd.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      code     <= ffba_pkg::ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == ffba_pkg::OP_FREE) ? S_FRD : S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.size_zero) begin
            code  <= ffba_pkg::ST_ZERO;
            state <= S_FIN;
          end else if (sts.over_pool) begin
            code  <= ffba_pkg::ST_OVER_POOL;
            state <= S_FIN;
          end else if (sts.over_free) begin
            code  <= ffba_pkg::ST_OVER_FREE;
            state <= S_FIN;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (sts.run_end) begin
            code  <= ffba_pkg::ST_NO_RUN;
            state <= S_FIN;
          end else if (sts.run_found) begin
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (sts.slot_end) begin
            code  <= ffba_pkg::ST_TABLE_FULL;
            state <= S_FIN;
          end else if (sts.slot_free) begin
            code  <= ffba_pkg::ST_OK;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (sts.fill_last) begin
            state <= S_FIN;
          end
        end
        S_FRD: state <= S_FCMP;
        S_FCMP: begin
          if (sts.hit) begin
            code  <= ffba_pkg::ST_OK;
            state <= S_FILL;
          end else if (sts.last_entry) begin
            code  <= ffba_pkg::ST_NOT_FOUND;
            state <= S_FIN;
          end else begin
            state <= S_FRD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/ffba_checker.sv
`include "first_fit_block_allocator_macros.svh"

module ffba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ffba_pkg::M_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  `FFBA_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")

  // errors carry no region
  `FFBA_ASSERT_IMP(a_err_zero, m_tvalid && (m_tdata[2:0] != ffba_pkg::ST_OK), m_tdata[21:3] == '0, "error result with region")

  // status code seven is never produced
  `FFBA_ASSERT_IMP(a_code, m_tvalid, m_tdata[2:0] != 3'd7, "undefined status code")

  // one request in flight: busy right after an accept
  `FFBA_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "second request taken while busy")

endmodule

bind first_fit_block_allocator ffba_checker u_chk (.*);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF;
  localparam int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF;
  localparam int unsigned POOL_CAP    = BLOCK_BYTES * MAX_BLOCKS;

  // pool sizes walked by the random part, extremes included
  localparam int unsigned N_PHASES = 12;
  localparam int unsigned PHASE_POOLS [N_PHASES] =
    '{4096, 8191, 1000, 0, 64, 65, 4095, 640, 1, 2048, 5000, 300};
  localparam int unsigned ITEMS_PER_PHASE = 146;
  localparam int unsigned CALM_PHASE      = 6;   // no idling on either side
  localparam int unsigned IDLE_PCT        = 27;
  localparam int unsigned DRAIN_CYCLES    = 300; // idle margin after the last result

  typedef struct packed {
    ffba_pkg::status_t               status;
    logic [ffba_pkg::OFF_W-1:0]      offset;
    logic [ffba_pkg::BLK_W-1:0]      blocks;
  } region_result_t;

  typedef enum logic {STEP_REQUEST, STEP_POOL} step_kind_t;

  typedef struct {
    step_kind_t     kind;
    logic           op;
    int unsigned    bytes;      // request size, or pool size for STEP_POOL
    int unsigned    offset;
    bit             typed;      // expected result given in the row
    region_result_t result;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [ffba_pkg::S_DATA_W-1:0]  s_tdata = '0;   // request_bytes[15:0], free_offset[27:16]
  logic                           s_tuser = 1'b0; // opcode
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [ffba_pkg::M_DATA_W-1:0]  m_tdata;        // status[2:0], region_offset[14:3],
                                                  // region_blocks[21:15]
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [ffba_pkg::PADDR_W-1:0]   paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator mirror: bitmap, allocation table, byte accounting, pool register
  // ---------------------------------------------------------------------------
  logic [ffba_pkg::POOL_W-1:0]  pool_reg = ffba_pkg::POOL_RESET;
  bit                           blk_busy  [MAX_BLOCKS];
  bit                           slot_live [MAX_BLOCKS];
  logic [5:0]                   slot_first[MAX_BLOCKS];
  logic [ffba_pkg::BLK_W-1:0]   slot_nblk [MAX_BLOCKS];
  logic [ffba_pkg::POOL_W-1:0]  slot_size [MAX_BLOCKS];
  logic [ffba_pkg::POOL_W-1:0]  bytes_taken = '0;

  region_result_t pending_results[$];  // one per accepted request, oldest first
  int unsigned    mismatch_count = 0;
  bit             calm = 1'b0;         // both sides run without idling

  // pool size as the block sees it, capped at the bitmap size
  function automatic int unsigned pool_limit();
    return (pool_reg > POOL_CAP) ? POOL_CAP : pool_reg;
  endfunction

  // Applies one request to the mirror and returns the result the block owes.
  function automatic region_result_t predict_request(logic op,
                                                      logic [ffba_pkg::REQ_W-1:0] req,
                                                      logic [ffba_pkg::OFF_W-1:0] off);
    int unsigned    pool, nblk, avail, need, run, first, slot, k;
    bit             hit;
    region_result_t r;
    r.status = ffba_pkg::ST_OK;
    r.offset = '0;
    r.blocks = '0;
    if (op == ffba_pkg::OP_ALLOC) begin
      pool  = pool_limit();
      nblk  = (pool + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (nblk > MAX_BLOCKS) nblk = MAX_BLOCKS;
      // pool shrunk under the live bytes: nothing free
      avail = (bytes_taken > pool) ? 0 : pool - bytes_taken;
      if (req == 0) r.status = ffba_pkg::ST_ZERO;
      else if (req > pool) r.status = ffba_pkg::ST_OVER_POOL;
      else if (req > avail) r.status = ffba_pkg::ST_OVER_FREE;
      else begin
        need  = (req + BLOCK_BYTES - 1) / BLOCK_BYTES;
        run   = 0;
        first = 0;
        hit   = 1'b0;
        // lowest run of free blocks that is long enough
        for (k = 0; k < nblk && !hit; k++) begin
          if (blk_busy[k]) run = 0;
          else begin
            if (run == 0) first = k;
            run++;
            if (run == need) hit = 1'b1;
          end
        end
        if (!hit) r.status = ffba_pkg::ST_NO_RUN;
        else begin
          // first free entry, searched only within the block count
          slot = nblk;
          for (k = 0; k < nblk; k++)
            if (!slot_live[k] && slot == nblk) slot = k;
          if (slot == nblk) r.status = ffba_pkg::ST_TABLE_FULL;
          else begin
            slot_live[slot]  = 1'b1;
            slot_first[slot] = first[5:0];
            slot_nblk[slot]  = need[ffba_pkg::BLK_W-1:0];
            slot_size[slot]  = req[ffba_pkg::POOL_W-1:0];
            for (k = first; k < first + need; k++) blk_busy[k] = 1'b1;
            bytes_taken = bytes_taken + req[ffba_pkg::POOL_W-1:0];
            r.offset = ffba_pkg::OFF_W'(first * BLOCK_BYTES);
            r.blocks = need[ffba_pkg::BLK_W-1:0];
          end
        end
      end
    end else begin
      slot = MAX_BLOCKS;
      for (k = 0; k < MAX_BLOCKS; k++)
        if (slot == MAX_BLOCKS && slot_live[k] &&
            int'(slot_first[k]) * BLOCK_BYTES == int'(off)) slot = k;
      if (slot == MAX_BLOCKS) r.status = ffba_pkg::ST_NOT_FOUND;
      else begin
        // entries past a shrunk pool are still released here
        for (k = slot_first[slot]; k < slot_first[slot] + slot_nblk[slot]; k++)
          blk_busy[k] = 1'b0;
        slot_live[slot] = 1'b0;
        bytes_taken = (bytes_taken > slot_size[slot]) ? bytes_taken - slot_size[slot] : '0;
        r.offset = ffba_pkg::OFF_W'(slot_first[slot] * BLOCK_BYTES);
        r.blocks = slot_nblk[slot];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one request after a random gap, waits for the handshake, then
  // updates the mirror. A typed row replaces the mirror's answer.
  task automatic issue_request(logic op, logic [ffba_pkg::REQ_W-1:0] req,
                               logic [ffba_pkg::OFF_W-1:0] off,
                               bit typed, region_result_t typed_res);
    region_result_t res;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, off, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = predict_request(op, req, off);
    if (typed) res = typed_res;
    pending_results.push_back(res);
  endtask

  // Pool writes only with the block idle: all results back, then a margin.
  task automatic set_pool_bytes(int unsigned value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ffba_pkg::PADDR_W'({ffba_pkg::REG_POOL, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_reg = value[ffba_pkg::POOL_W-1:0];
  endtask

  // Random request: mostly allocations and frees of live regions, some noise.
  task automatic random_request();
    int unsigned roll, cap, k;
    int unsigned live_q[$];
    logic                       op;
    logic [ffba_pkg::REQ_W-1:0] req;
    logic [ffba_pkg::OFF_W-1:0] off;
    region_result_t             none;
    none = '0;
    req  = ffba_pkg::REQ_W'($urandom);
    off  = ffba_pkg::OFF_W'($urandom);
    roll = $urandom_range(0, 99);
    cap  = (pool_limit() < 8) ? 8 : pool_limit();
    if (roll < 45) begin
      op = ffba_pkg::OP_ALLOC;
      case ($urandom_range(0, 9))
        0: case ($urandom_range(0, 2))
             0: req = '0;
             1: req = '1;
             default: req = ffba_pkg::REQ_W'($urandom);
           endcase
        1, 2, 3, 4: req = ffba_pkg::REQ_W'($urandom_range(1, cap / 8));
        5, 6: req = ffba_pkg::REQ_W'($urandom_range(1, BLOCK_BYTES));
        7: req = ffba_pkg::REQ_W'($urandom_range(1, cap / 2));
        8: req = ffba_pkg::REQ_W'($urandom_range(1, 4) * BLOCK_BYTES);
        default: req = ffba_pkg::REQ_W'($urandom_range(1, POOL_CAP));
      endcase
    end else if (roll < 85) begin
      op = ffba_pkg::OP_FREE;
      for (k = 0; k < MAX_BLOCKS; k++)
        if (slot_live[k]) live_q.push_back(k);
      if (live_q.size() != 0) begin
        k = live_q[$urandom_range(0, live_q.size() - 1)];
        off = ffba_pkg::OFF_W'(slot_first[k] * BLOCK_BYTES);
      end
    end else begin
      // stray frees: block-aligned or anywhere
      op = ffba_pkg::OP_FREE;
      if ($urandom_range(0, 1))
        off = ffba_pkg::OFF_W'($urandom_range(0, MAX_BLOCKS - 1) * BLOCK_BYTES);
      else off = ffba_pkg::OFF_W'($urandom_range(0, 4095));
    end
    issue_request(op, req, off, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order compare
  // ---------------------------------------------------------------------------
  region_result_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
          mismatch_count++;
        end
        if (m_tdata[14:3] !== want.offset) begin
          $error("region_offset: expected %0d, got %0d", want.offset, m_tdata[14:3]);
          mismatch_count++;
        end
        if (m_tdata[21:15] !== want.blocks) begin
          $error("region_blocks: expected %0d, got %0d", want.blocks, m_tdata[21:15]);
          mismatch_count++;
        end
      end
    end
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  step_t plan[$];

  task automatic add_step(step_kind_t kind, logic op, int unsigned bytes, int unsigned off,
                          bit typed, ffba_pkg::status_t st, int unsigned eoff,
                          int unsigned eblk);
    step_t s;
    s.kind          = kind;
    s.op            = op;
    s.bytes         = bytes;
    s.offset        = off;
    s.typed         = typed;
    s.result.status = st;
    s.result.offset = ffba_pkg::OFF_W'(eoff);
    s.result.blocks = ffba_pkg::BLK_W'(eblk);
    plan.push_back(s);
  endtask

  initial begin
    int unsigned i, p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pool of 4096 bytes, 64 blocks
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 0,     0,    1, ffba_pkg::ST_ZERO,      0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 65535, 0,    1, ffba_pkg::ST_OVER_POOL, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 4097,  0,    1, ffba_pkg::ST_OVER_POOL, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     4095, 1, ffba_pkg::ST_NOT_FOUND, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 4096,  0,    1, ffba_pkg::ST_OK,        0, 64);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    1, ffba_pkg::ST_OVER_FREE, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     0,    1, ffba_pkg::ST_OK,        0, 64);
    // fragment the bitmap so the table order differs from block order
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    1, ffba_pkg::ST_OK,        0, 1);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     128,  0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 65,    0,    0, ffba_pkg::ST_OK,        0, 0);
    // two blocks: a free block exists but both table entries are taken
    add_step(STEP_POOL,    ffba_pkg::OP_ALLOC, 128,   0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    1, ffba_pkg::ST_TABLE_FULL, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 65,    0,    1, ffba_pkg::ST_OVER_FREE, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 129,   0,    1, ffba_pkg::ST_OVER_POOL, 0, 0);
    // empty pool, live regions beyond it are still freed
    add_step(STEP_POOL,    ffba_pkg::OP_ALLOC, 0,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    1, ffba_pkg::ST_OVER_POOL, 0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     256,  1, ffba_pkg::ST_OK,        256, 2);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     64,   1, ffba_pkg::ST_OK,        64, 1);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     192,  1, ffba_pkg::ST_OK,        192, 1);
    // three blocks with a one-block hole: no run for two
    add_step(STEP_POOL,    ffba_pkg::OP_ALLOC, 192,   0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 1,     0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     64,   1, ffba_pkg::ST_OK,        64, 1);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 65,    0,    1, ffba_pkg::ST_NO_RUN,    0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     0,    1, ffba_pkg::ST_OK,        0, 1);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     128,  1, ffba_pkg::ST_OK,        128, 1);
    // oversized pool is capped at the bitmap size
    add_step(STEP_POOL,    ffba_pkg::OP_ALLOC, 8191,  0,    0, ffba_pkg::ST_OK,        0, 0);
    add_step(STEP_REQUEST, ffba_pkg::OP_ALLOC, 4096,  0,    1, ffba_pkg::ST_OK,        0, 64);
    add_step(STEP_REQUEST, ffba_pkg::OP_FREE,  0,     0,    1, ffba_pkg::ST_OK,        0, 64);

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == STEP_POOL) set_pool_bytes(plan[i].bytes);
      else issue_request(plan[i].op, ffba_pkg::REQ_W'(plan[i].bytes),
                         ffba_pkg::OFF_W'(plan[i].offset), plan[i].typed, plan[i].result);
    end

    // random phases, live regions carried across pool changes
    for (p = 0; p < N_PHASES; p++) begin
      set_pool_bytes(PHASE_POOLS[p]);
      calm = (p == CALM_PHASE);
      for (i = 0; i < ITEMS_PER_PHASE; i++) random_request();
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[first_fit_block_allocator] OK");
    else
      $display("[first_fit_block_allocator] ERROR");
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[first_fit_block_allocator] ERROR");
    $finish;
  end

endmodule
